// ===== rtl/chained_hash_map_assign_read_macros.svh =====
// Assertion macros shared by the checker.
`ifndef CHAINED_HASH_MAP_ASSIGN_READ_MACROS_SVH
`define CHAINED_HASH_MAP_ASSIGN_READ_MACROS_SVH
// Implication checked every clock outside reset.
`define CHM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked every clock outside reset.
`define CHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/chm_pkg.sv =====
// ---------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map.
// ---------------------------------------------------------------------------
`default_nettype none
package chm_pkg;
  localparam int MaxBuckets = 256;
  localparam int MaxNodes   = 1024;
  localparam int BktW  = $clog2(MaxBuckets);
  localparam int NodeW = $clog2(MaxNodes);
  localparam int PtrW  = NodeW + 1;
  localparam int KeyW  = 32;
  localparam int ValW  = 64;
  localparam int CntW  = 9;
  localparam logic [PtrW-1:0] NilPtr = PtrW'(MaxNodes);
  localparam logic KindAssign = 1'b0;
  localparam logic KindRead   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_HEAD, ST_HEADW, ST_NODE, ST_NODEW,
    ST_CMP, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;    // write one empty head, advance sweep
    logic load;        // capture input word, start remainder
    logic div_step;    // one restoring remainder step
    logic head_rd;     // read bucket head
    logic head_cap;    // take head as current pointer
    logic node_rd;     // read node at current pointer
    logic follow;      // take node_next as current pointer
    logic upd_val;     // overwrite value of hit node
    logic ins;         // insert new node at chain head
    logic set_full;    // flag pool full
    logic out_load;    // load output register
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic ptr_nil;
    logic key_hit;
    logic is_read;
    logic pool_full;
    logic steps_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/chained_hash_map_assign_read.sv =====
// ---------------------------------------------------------------------------
// chained_hash_map_assign_read
// Hash map with separate chaining: assign and read of 64-bit values by key.
// ---------------------------------------------------------------------------
// The input channel (in_valid/in_stall) carries one word: kind, key and
// new_value. The output channel (out_valid/out_stall) returns one word per
// input: read_value and status. The bucket count register is written through
// cfg_valid/cfg_ready; the user must write it only while the block is idle,
// which the block itself does not enforce. Each word is handled alone. The
// bucket index comes from a restoring remainder unit, then the bucket head is
// read (head read and capture states) and the chain is walked node by node
// through the node memory port, with a read, a wait and a compare state per
// node. The update and the output load follow, and a miss ends with one more
// visit of the node read state, on the empty link.
// After reset a clearing pass writes all 256 bucket heads empty, one per
// cycle; in_stall stays high during the pass.
// While the receiver holds out_stall, the result stays in the output register.
// The next word may still be taken and worked on, but its result waits until
// the pending result has gone.
// A key that misses still costs the full chain walk; a read of a missing key
// returns zero, and an assign with a full pool returns status one.
// ---------------------------------------------------------------------------
`default_nettype none
module chained_hash_map_assign_read (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  bucket_count,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [31:0] key,
  input  wire logic signed [63:0] new_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [63:0] read_value,
  output logic             status
);
  import chm_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [CntW-1:0] bucket_reg;

  // Configuration is always accepted; the user must write it only while the block is idle.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_reg <= CntW'(MaxBuckets);
    else if (cfg_valid && cfg_ready) bucket_reg <= bucket_count;
  end

  chm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid), .sts(sts), .cmd(cmd)
  );

  chm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .bucket_count(bucket_reg),
    .kind(kind), .key(key), .new_value(new_value), .out_stall(out_stall),
    .out_valid(out_valid), .read_value(read_value), .status(status)
  );
endmodule
`default_nettype wire

// ===== rtl/chm_ctrl.sv =====
// ---------------------------------------------------------------------------
// chm_ctrl
// Controller state machine sequencing head clearing, modulo, head read, chain walk, update and output.
// ---------------------------------------------------------------------------
`default_nettype none
module chm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           out_busy,
  input  wire chm_pkg::sts_t  sts,
  output chm_pkg::cmd_t       cmd
);
  import chm_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_DIV;
      ST_DIV:   if (sts.div_done) state_next = ST_HEAD;
      ST_HEAD:  state_next = ST_HEADW;
      ST_HEADW: state_next = ST_NODE;
      ST_NODE:  state_next = sts.ptr_nil ? ST_WRITE : ST_NODEW;
      ST_NODEW: state_next = ST_CMP;
      ST_CMP: begin
        if (sts.key_hit || sts.steps_done) state_next = ST_WRITE;
        else state_next = ST_NODE;
      end
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (!out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_HEAD:  cmd.head_rd = 1'b1;
      ST_HEADW: cmd.head_cap = 1'b1;
      ST_NODE:  cmd.node_rd = !sts.ptr_nil;
      ST_NODEW: ;
      ST_CMP:   cmd.follow = !sts.key_hit;
      ST_WRITE: begin
        if (!sts.is_read) begin
          if (!sts.ptr_nil) cmd.upd_val = 1'b1;
          else if (!sts.pool_full) cmd.ins = 1'b1;
          else cmd.set_full = 1'b1;
        end
      end
      ST_OUT:   cmd.out_load = !out_busy;
      default:  ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/chm_dp.sv =====
// ---------------------------------------------------------------------------
// chm_dp
// Datapath: remainder unit, head table, node pool and output register.
// ---------------------------------------------------------------------------
`default_nettype none
module chm_dp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire chm_pkg::cmd_t           cmd,
  output chm_pkg::sts_t                sts,
  input  wire logic [chm_pkg::CntW-1:0] bucket_count,
  input  wire logic                    kind,
  input  wire logic [chm_pkg::KeyW-1:0] key,
  input  wire logic signed [chm_pkg::ValW-1:0] new_value,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic signed [chm_pkg::ValW-1:0] read_value,
  output logic                         status
);
  import chm_pkg::*;

  logic [PtrW-1:0] head_mem [MaxBuckets];
  logic [KeyW-1:0] key_mem  [MaxNodes];
  logic [ValW-1:0] val_mem  [MaxNodes];
  logic [PtrW-1:0] next_mem [MaxNodes];

  logic            op_kind;
  logic [KeyW-1:0] op_key;
  logic [ValW-1:0] op_val;
  logic [CntW-1:0] divisor;
  logic [KeyW-1:0] quo;
  logic [CntW:0]   rem;
  logic [5:0]      bitcnt;
  logic [BktW-1:0] bucket;
  logic [BktW:0]   clr_idx;
  logic [PtrW-1:0] cur, head_q, next_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [PtrW-1:0] used;
  logic [NodeW:0]  steps;
  logic            full_flag;
  logic [CntW:0]   trial;

  assign trial = {rem[CntW-1:0], quo[KeyW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.ins) used <= used + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) head_mem[clr_idx[BktW-1:0]] <= NilPtr;
    if (cmd.ins) head_mem[bucket] <= used;
    if (cmd.head_rd) head_q <= head_mem[bucket];
  end

  // A new node links to the old head of its bucket, still held in head_q.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      key_mem[used[NodeW-1:0]]  <= op_key;
      next_mem[used[NodeW-1:0]] <= head_q;
    end
    if (cmd.ins) val_mem[used[NodeW-1:0]] <= op_val;
    else if (cmd.upd_val) val_mem[cur[NodeW-1:0]] <= op_val;
    if (cmd.node_rd) begin
      key_q  <= key_mem[cur[NodeW-1:0]];
      val_q  <= val_mem[cur[NodeW-1:0]];
      next_q <= next_mem[cur[NodeW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= kind;
      op_key  <= key;
      op_val  <= new_value;
      quo     <= key;
      rem     <= '0;
      bitcnt  <= '0;
      steps   <= '0;
      full_flag <= 1'b0;
      if (bucket_count == '0) divisor <= CntW'(1);
      else if (bucket_count > CntW'(MaxBuckets)) divisor <= CntW'(MaxBuckets);
      else divisor <= bucket_count;
    end
    if (cmd.div_step) begin
      quo <= {quo[KeyW-2:0], 1'b0};
      bitcnt <= bitcnt + 1'b1;
      if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
      else rem <= trial;
    end
    if (cmd.head_cap) begin
      bucket <= bucket;
      cur <= head_q;
    end
    if (cmd.div_step && bitcnt == 6'(KeyW - 1)) begin
      if (trial >= {1'b0, divisor}) bucket <= BktW'(trial - {1'b0, divisor});
      else bucket <= BktW'(trial);
    end
    if (cmd.node_rd) steps <= steps + 1'b1;
    if (cmd.follow) cur <= next_q;
    if (cmd.set_full) full_flag <= 1'b1;
    if (cmd.out_load) begin
      read_value <= (op_kind == KindRead && cur != NilPtr) ? val_q : '0;
      status <= full_flag;
    end
  end

  always_comb begin
    sts.clr_done   = (clr_idx == (BktW+1)'(MaxBuckets - 1));
    sts.div_done   = (bitcnt == 6'(KeyW - 1));
    sts.ptr_nil    = (cur == NilPtr);
    sts.key_hit    = (key_q == op_key);
    sts.is_read    = (op_kind == KindRead);
    sts.pool_full  = (used == PtrW'(MaxNodes));
    sts.steps_done = (steps == (NodeW+1)'(MaxNodes));
  end
endmodule
`default_nettype wire

// ===== rtl/chm_checker.sv =====
// ---------------------------------------------------------------------------
// chm_checker
// Port-level checks of the chained hash map, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_map_assign_read_macros.svh"
module chm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        status,
  input wire logic [63:0] read_value
);
  // A word taken in keeps the input stalled in the next cycle.
  `CHM_ASSERT_NEXT(a_no_instant, clk, rst, in_valid && !in_stall, in_stall, "input not held off")
  // A result taken leaves the output empty in the next cycle.
  `CHM_ASSERT_NEXT(a_one_at_time, clk, rst, out_valid && !out_stall, !out_valid, "result repeated")
  // A full flag comes only with a zero value.
  `CHM_ASSERT_IMP(a_full_zero, clk, rst, out_valid && status, read_value == 64'd0, "bad full result")
  // A stalled result holds.
  `CHM_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(read_value), "result changed")
endmodule
bind chained_hash_map_assign_read chm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .read_value(read_value)
);
`default_nettype wire

// ===== tb/sv/tb_chained_hash_map_assign_read.sv =====
// ---------------------------------------------------------------------------
// Chained hash map testbench
// Drives assign and read words into the hash map, predicts every answer from
// a behavioral copy of the table kept here, and compares the answers as they
// come out under several bucket counts, back-pressure patterns and pool fill.
// ---------------------------------------------------------------------------
module tb_chained_hash_map_assign_read;
  import chm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam int PressureHold = 700;

  // One input word and one answer word.
  typedef struct {
    logic             op;
    logic [KeyW-1:0]  k;
    logic [ValW-1:0]  v;
  } map_word_t;

  typedef struct {
    logic [ValW-1:0] value;
    logic            full;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CntW-1:0] cfg_buckets = 9'd0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              kind = KindAssign;
  logic [KeyW-1:0]   key = '0;
  logic [ValW-1:0]   new_value = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ValW-1:0]   read_value;
  logic              status;

  chained_hash_map_assign_read u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .bucket_count (cfg_buckets),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .key          (key),
    .new_value    (new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_value   (read_value),
    .status       (status)
  );

  // The table as the testbench sees it. Only links written with their node
  // are ever followed, so the pool arrays need no reset.
  logic [CntW-1:0]  shadow_buckets;
  logic [PtrW-1:0]  shadow_head [MaxBuckets];
  logic [KeyW-1:0]  shadow_key  [MaxNodes];
  logic [ValW-1:0]  shadow_val  [MaxNodes];
  logic [PtrW-1:0]  shadow_next [MaxNodes];
  int               shadow_used;

  map_word_t words_to_send [$];
  answer_t   answers_due [$];
  logic [KeyW-1:0] stored_keys [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit send_hold = 1'b0;
  int hold_request = 0;
  int hold_taken = 0;
  int hold_left = 0;

  // Clock; the single reset pulse is released in the main sequence below.
  initial begin
    forever #1 clk = ~clk;
  end

  // Work out the answer to one accepted word and update the shadow table.
  function automatic answer_t map_apply(input map_word_t w);
    answer_t   a;
    int        divisor;
    int        bkt;
    int        at;
    int        steps;
    int        hit;
    a.value = '0;
    a.full = 1'b0;
    divisor = shadow_buckets;
    if (divisor == 0) divisor = 1;
    if (divisor > MaxBuckets) divisor = MaxBuckets;
    bkt = w.k % divisor;
    at = shadow_head[bkt];
    hit = -1;
    steps = 0;
    while (at < MaxNodes && steps < MaxNodes && hit < 0) begin
      if (shadow_key[at] == w.k) begin
        hit = at;
      end else begin
        at = shadow_next[at];
        steps++;
      end
    end
    if (w.op == KindRead) begin
      if (hit >= 0) a.value = shadow_val[hit];
    end else if (hit >= 0) begin
      shadow_val[hit] = w.v;
    end else if (shadow_used < MaxNodes) begin
      shadow_key[shadow_used] = w.k;
      shadow_val[shadow_used] = w.v;
      shadow_next[shadow_used] = shadow_head[bkt];
      shadow_head[bkt] = PtrW'(shadow_used);
      shadow_used++;
    end else begin
      a.full = 1'b1;
    end
    return a;
  endfunction

  // Driver: a word leaves the port when it is taken (valid high, stall low);
  // only then is the prediction made and the next word considered. A stalled
  // word holds still.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        answers_due.push_back(map_apply('{kind, key, new_value}));
      end
      if (words_to_send.size() > 0 && !send_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        kind      <= words_to_send[0].op;
        key       <= words_to_send[0].k;
        new_value <= words_to_send[0].v;
        in_valid  <= 1'b1;
        void'(words_to_send.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so that the sender keeps offering
  // words while the answer sits in the output register.
  always @(posedge clk) begin
    if (hold_request != hold_taken) begin
      hold_taken <= hold_request;
      hold_left <= PressureHold;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each answer taken from the port with the oldest one due,
  // then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: answer with none due: value %h status %b",
                 $realtime, read_value, status);
      end else begin
        if (read_value !== answers_due[0].value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h",
                   $realtime, answers_due[0].value, read_value);
        end
        if (status !== answers_due[0].full) begin
          errors++;
          $display("%0t: status expected %b actual %b",
                   $realtime, answers_due[0].full, status);
        end
        void'(answers_due.pop_front());
      end
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_word(input logic op, input logic [KeyW-1:0] k,
                            input logic [ValW-1:0] v);
    words_to_send.push_back('{op, k, v});
    if (op == KindAssign) stored_keys.push_back(k);
  endtask

  // Random word: a key seen before so that hits and overwrites happen, or, at
  // fresh_pct percent, a fresh 32-bit key that inserts or misses.
  task automatic queue_random(input int count, input int assign_pct,
                              input int fresh_pct);
    logic [KeyW-1:0] k;
    logic            op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < assign_pct) ? KindAssign : KindRead;
      if (stored_keys.size() == 0 || $urandom_range(99) < fresh_pct)
        k = $urandom;
      else
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      queue_word(op, k, {$urandom, $urandom});
    end
  endtask

  // Let every queued word go through and every answer come back.
  task automatic drain();
    while (words_to_send.size() > 0 || in_valid || answers_due.size() > 0)
      @(posedge clk);
  endtask

  // Register write while the map is idle.
  task automatic write_buckets(input logic [CntW-1:0] n);
    drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_buckets <= n;
    do @(posedge clk); while (!cfg_ready);
    shadow_buckets = n;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    drain();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    shadow_buckets = 9'd256;
    shadow_used = 0;
    for (int b = 0; b < MaxBuckets; b++) shadow_head[b] = NilPtr;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Single bucket: everything chains together.
    write_buckets(9'd1);
    queue_word(KindAssign, 32'h0, 64'h7fff_ffff_ffff_ffff);
    queue_word(KindAssign, 32'hffff_ffff, 64'h8000_0000_0000_0000);
    queue_word(KindRead, 32'h0, 64'h0);
    queue_word(KindRead, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    queue_word(KindRead, 32'h5, 64'h1234);
    queue_word(KindAssign, 32'h0, 64'hffff_ffff_ffff_ffff);
    queue_word(KindRead, 32'h0, 64'h0);
    queue_word(KindAssign, 32'h5555_aaaa, 64'h0);
    queue_word(KindRead, 32'h5555_aaaa, 64'h0);

    // A zero bucket count behaves as one.
    write_buckets(9'd0);
    queue_word(KindAssign, 32'haaaa_5555, 64'h5555_aaaa_5555_aaaa);
    queue_word(KindRead, 32'haaaa_5555, 64'h0);
    queue_word(KindRead, 32'h0, 64'h0);

    // Above the table size the count is clamped; old nodes in bucket zero
    // stay reachable only for keys that still map there.
    write_buckets(9'd511);
    queue_word(KindAssign, 32'h100, 64'haaaa_5555_aaaa_5555);
    queue_word(KindRead, 32'h100, 64'h0);
    queue_word(KindRead, 32'hffff_ffff, 64'h0);
    queue_word(KindRead, 32'h0, 64'h0);
    queue_word(KindAssign, 32'hffff_ffff, 64'h1);
    queue_word(KindRead, 32'hffff_ffff, 64'h0);

    write_buckets(9'd256);
    set_idling(0, 0);
    queue_random(300, 75, 60);
    set_idling(69, 0);
    queue_random(250, 75, 60);

    // A mid-size modulo makes longer chains and strands some keys.
    write_buckets(9'd100);
    set_idling(0, 69);
    queue_random(250, 70, 55);
    set_idling(23, 23);
    queue_random(250, 70, 55);

    // Receiver holds off for a long stretch while words keep coming.
    write_buckets(9'd256);
    set_idling(0, 0);
    hold_request = hold_request + 1;
    queue_random(60, 70, 50);

    // Sender pauses until every answer is back, then the pool is run dry.
    drain();
    send_hold = 1'b1;
    repeat (20) @(posedge clk);
    send_hold = 1'b0;
    set_idling(23, 23);
    queue_random((MaxNodes > shadow_used ? MaxNodes - shadow_used : 0) + 40, 100, 100);

    // Pool full: overwrites still land, new keys are refused.
    set_idling(69, 69);
    queue_random(150, 60, 40);
    set_idling(0, 0);
    queue_random(200, 60, 30);

    // One bucket over a full pool: the longest walks.
    write_buckets(9'd1);
    queue_random(8, 50, 50);
    write_buckets(9'd256);
    queue_random(20, 50, 50);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
